[rtl/core/pjmr_pkg.sv]
// Package for the Pade-Jastrow move ratio block.
// Holds the channel payload types, request and register codes, fixed-point
// constants and the request/response types of the shared divider.
package pjmr_pkg;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_MOVE   = 2'd1;
  localparam logic [1:0] REQ_REJECT = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS  = 2'd1;

  // Register reset values.
  localparam logic [19:0] GAMMA_RESET = 20'd65536;
  localparam logic [1:0]  DIMS_RESET  = 2'd3;

  // Fixed-point constants.
  localparam logic [31:0] ONE_Q16   = 32'd65536;
  localparam logic [31:0] RATIO_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0] LN2_Q32   = 32'hB172_17F8;
  // Exponent limit of 12.0 in Q16.16.
  localparam int EXP_LIMIT = 786432;
  // Bias on the ln2 count so that the division runs on a positive value.
  localparam int LN2_BIAS = 18;
  localparam logic [35:0] LN2_BIAS_Q32 = 36'd53586800496;
  // Number of Taylor terms after the constant one.
  localparam logic [3:0] TAYLOR_TERMS = 4'd13;

  // Shared divider widths.
  localparam int DVD_W = 66;
  localparam int DSR_W = 54;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         particle;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } pjmr_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [31:0] ratio;
    logic        saturated;
  } pjmr_out_t;

  // Divider request and response.
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DSR_W-1:0] rem;
  } div_rsp_t;

endpackage

[rtl/core/pjmr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pjmr_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

[rtl/core/pjmr_div.sv]
// Shared restoring divider, one quotient bit per cycle over 66 steps.
// Depends on pjmr_pkg for the request and response types.
module pjmr_div (
  input  logic               clk,
  input  logic               rst_n,
  input  pjmr_pkg::div_req_t req,
  output pjmr_pkg::div_rsp_t rsp
);
  import pjmr_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [6:0]       cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DSR_W-1:0] dsr_r;
  logic [DSR_W-1:0] rem_r;
  logic [DVD_W-1:0] quo_r;

  logic [DSR_W:0]   rem_sh;
  logic [DSR_W:0]   rem_diff;
  logic             fits;
  logic [DSR_W-1:0] rem_nxt;

  // One shift-compare-subtract step.
  always_comb begin
    rem_sh   = {rem_r, dvd_r[DVD_W-1]};
    rem_diff = rem_sh - {1'b0, dsr_r};
    fits     = (rem_sh >= {1'b0, dsr_r});
    rem_nxt  = fits ? rem_diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
  end

  // Control: busy while steps remain, done for one cycle at the end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

[rtl/core/pade_jastrow_move_ratio.sv]
// Pade-Jastrow move ratio unit: keeps one Q16.16 position per particle in a
// small RAM and answers each transaction with one Q16.16 ratio. For a move,
// for every other particle two distances are squared on one shared multiplier,
// rooted one bit a cycle and divided for the Pade term on one shared 66-step
// divider; the exponential then uses that divider fifteen more times.
// The input is not ready while a transaction is being worked on; the result
// waits in an output register. Configuration is always accepted.
module pade_jastrow_move_ratio #(
  parameter int PARTICLES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pjmr_pkg::pjmr_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output pjmr_pkg::pjmr_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pjmr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pjmr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pjmr_pkg::*;

  localparam int AW   = $clog2(PARTICLES);
  localparam int HALF = PARTICLES / 2;

  // Sequencer state codes.
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_SAVE   = 5'd1;
  localparam logic [4:0] S_JSEL   = 5'd2;
  localparam logic [4:0] S_JLOAD  = 5'd3;
  localparam logic [4:0] S_SQ     = 5'd4;
  localparam logic [4:0] S_SQW    = 5'd5;
  localparam logic [4:0] S_SQA    = 5'd6;
  localparam logic [4:0] S_SQRT   = 5'd7;
  localparam logic [4:0] S_GR     = 5'd8;
  localparam logic [4:0] S_GRW    = 5'd9;
  localparam logic [4:0] S_HSTART = 5'd10;
  localparam logic [4:0] S_HDIV   = 5'd11;
  localparam logic [4:0] S_XPREP  = 5'd12;
  localparam logic [4:0] S_XDIV   = 5'd13;
  localparam logic [4:0] S_NSTART = 5'd14;
  localparam logic [4:0] S_NDIV   = 5'd15;
  localparam logic [4:0] S_TMUL   = 5'd16;
  localparam logic [4:0] S_TMW    = 5'd17;
  localparam logic [4:0] S_TDST   = 5'd18;
  localparam logic [4:0] S_TDW    = 5'd19;
  localparam logic [4:0] S_SHIFT  = 5'd20;
  localparam logic [4:0] S_FIN    = 5'd21;

  // Exponent bounds for the two dimension modes.
  localparam logic signed [47:0] HI_2D = 48'sd2359299;
  localparam logic signed [47:0] LO_2D = 48'sd2359296;
  localparam logic signed [47:0] HI_3D = 48'sd1572866;
  localparam logic signed [47:0] LO_3D = 48'sd1572864;

  logic [4:0]  state_r;
  logic [19:0] gamma_r;
  logic [1:0]  dims_r;

  logic [95:0]   new_pos_r;
  logic [95:0]   saved_pos_r;
  logic [95:0]   other_r;
  logic [5:0]    saved_part_r;
  logic          pending_r;
  logic [AW-1:0] p_r;
  logic [AW:0]   jj_r;
  logic          side_r;
  logic [1:0]    dim_r;

  logic [32:0] mul_a_r;
  logic [32:0] mul_b_r;
  logic [65:0] mul_p_r;

  logic [65:0] sq_acc_r;
  logic [32:0] root_r;
  logic [34:0] srem_r;
  logic [5:0]  step_r;
  logic [32:0] hnew_r;

  logic signed [41:0] ssym_r;
  logic signed [41:0] sasym_r;

  logic [37:0]       u_r;
  logic signed [5:0] n_r;
  logic [31:0]       f_r;
  logic [32:0]       term_r;
  logic [35:0]       sum_r;
  logic [3:0]        k_r;

  logic [31:0] res_ratio_r;
  logic        res_sat_r;
  logic        out_valid_r;
  pjmr_out_t   out_data_r;

  logic         ram_we;
  logic [AW-1:0] ram_waddr;
  logic [95:0]  ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [95:0]  ram_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        in_take;
  logic        in_pv;
  logic        is2d;
  logic [1:0]  last_dim;

  // Position storage.
  pjmr_ram #(
    .WIDTH(96),
    .DEPTH(PARTICLES)
  ) u_pos_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr  (ram_raddr),
    .rdata_r(ram_rdata)
  );

  // Shared divider.
  pjmr_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_take   = in_valid && in_ready;
  assign in_pv     = ({1'b0, in_data.particle} < 7'(PARTICLES));
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign is2d      = (dims_r == 2'd2);
  assign last_dim  = is2d ? 2'd1 : 2'd2;

  function automatic logic [31:0] coord_of(input logic [95:0] pos, input logic [1:0] d);
    logic [31:0] c;
    case (d)
      2'd0:    c = pos[31:0];
      2'd1:    c = pos[63:32];
      default: c = pos[95:64];
    endcase
    return c;
  endfunction

  // Absolute coordinate difference for the current dimension.
  logic [31:0] ca;
  logic [31:0] cb;
  logic [32:0] cdiff;
  logic [32:0] cabs;
  always_comb begin
    ca    = coord_of(side_r ? saved_pos_r : new_pos_r, dim_r);
    cb    = coord_of(other_r, dim_r);
    cdiff = {ca[31], ca} - {cb[31], cb};
    cabs  = cdiff[32] ? (33'd0 - cdiff) : cdiff;
  end

  // One square-root step.
  logic [36:0] srem_sh;
  logic [34:0] strial;
  logic        sfits;
  logic [36:0] srem_diff;
  always_comb begin
    srem_sh   = {srem_r, sq_acc_r[65:64]};
    strial    = {root_r[32:0], 2'b01};
    sfits     = (srem_sh >= {2'b00, strial});
    srem_diff = srem_sh - {2'b00, strial};
  end

  // Difference of Pade terms and its half class.
  logic signed [34:0] dh;
  logic               same_half;
  always_comb begin
    dh        = $signed({2'b00, hnew_r}) - $signed({2'b00, div_rsp.quot[32:0]});
    same_half = (jj_r < (AW+1)'(HALF)) == ({1'b0, p_r} < (AW+1)'(HALF));
  end

  // Weighted exponent numerator and its range checks.
  logic signed [47:0] s48;
  logic signed [47:0] a48;
  logic signed [47:0] nsum;
  logic signed [47:0] hi_lim;
  logic signed [47:0] lo_lim;
  logic signed [47:0] mval;
  logic               x_hi;
  logic               x_lo;
  always_comb begin
    s48    = 48'(ssym_r);
    a48    = 48'(sasym_r);
    nsum   = is2d ? ((s48 <<< 1) + (a48 <<< 2) + (a48 <<< 1)) : (s48 + (a48 <<< 1));
    hi_lim = is2d ? HI_2D : HI_3D;
    lo_lim = is2d ? LO_2D : LO_3D;
    x_hi   = (nsum >= hi_lim);
    x_lo   = (nsum < (48'sd0 - lo_lim));
    mval   = nsum + lo_lim;
  end

  // Exponent back from the biased quotient, then biased for the ln2 split.
  logic signed [23:0] xval;
  logic signed [39:0] uval;
  always_comb begin
    xval = $signed({1'b0, div_rsp.quot[22:0]}) - 24'sd786432;
    uval = $signed({xval, 16'b0}) + $signed({4'b0, LN2_BIAS_Q32});
  end

  // Final scaling by a power of two with rounding.
  logic [5:0]  rsh;
  logic [36:0] rnd;
  logic [36:0] scaled;
  always_comb begin
    rsh = 6'(6'sd16 - n_r);
    rnd = 37'd0;
    if (n_r >= 6'sd16) begin
      scaled = (n_r == 6'sd17) ? {sum_r, 1'b0} : {1'b0, sum_r};
    end else begin
      rnd    = 37'd1 << (rsh - 6'd1);
      scaled = ({1'b0, sum_r} + rnd) >> rsh;
    end
  end

  // RAM port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = p_r;
    ram_wdata = new_pos_r;
    ram_raddr = (state_r == S_IDLE) ? in_data.particle[AW-1:0] : jj_r[AW-1:0];
    if (in_take && in_data.req_type == REQ_LOAD && in_pv) begin
      ram_we    = 1'b1;
      ram_waddr = in_data.particle[AW-1:0];
      ram_wdata = {in_data.coord_z, in_data.coord_y, in_data.coord_x};
    end else if (in_take && in_data.req_type == REQ_REJECT && pending_r) begin
      ram_we    = 1'b1;
      ram_waddr = saved_part_r[AW-1:0];
      ram_wdata = saved_pos_r;
    end else if (state_r == S_SAVE) begin
      ram_we = 1'b1;
    end
  end

  // Divider requests.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state_r)
      S_HSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = {1'b0, root_r, 32'b0};
        div_req.divisor  = 54'h1_0000_0000 + mul_p_r[53:0];
      end
      S_XPREP: begin
        div_req.start    = !x_hi && !x_lo;
        div_req.dividend = 66'(mval[22:0]);
        div_req.divisor  = is2d ? 54'd3 : 54'd2;
      end
      S_NSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = 66'(u_r);
        div_req.divisor  = 54'(LN2_Q32);
      end
      S_TDST: begin
        div_req.start    = 1'b1;
        div_req.dividend = 66'(mul_p_r[65:32]);
        div_req.divisor  = 54'(k_r);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // Shared multiplier with registered product.
  always_ff @(posedge clk) begin
    mul_p_r <= mul_a_r * mul_b_r;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= GAMMA_RESET;
      dims_r  <= DIMS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_GAMMA) begin
        gamma_r <= cfg_data[19:0];
      end else if (cfg_index == CFG_DIMS) begin
        dims_r <= cfg_data[1:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
      out_data_r.ratio     <= res_ratio_r;
      out_data_r.saturated <= res_sat_r;
    end
  end

  // Sequencer control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pending_r    <= 1'b0;
      saved_part_r <= '0;
      saved_pos_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_take) begin
            if (in_data.req_type == REQ_LOAD) begin
              if (in_pv) begin
                pending_r <= 1'b0;
              end
              state_r <= S_FIN;
            end else if (in_data.req_type == REQ_MOVE && in_pv) begin
              state_r <= S_SAVE;
            end else if (in_data.req_type == REQ_REJECT) begin
              pending_r <= 1'b0;
              state_r   <= S_FIN;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_SAVE: begin
          saved_pos_r  <= ram_rdata;
          saved_part_r <= 6'(p_r);
          pending_r    <= 1'b1;
          state_r      <= S_JSEL;
        end
        S_JSEL: begin
          if (jj_r == (AW+1)'(PARTICLES)) begin
            state_r <= S_XPREP;
          end else if (jj_r[AW-1:0] != p_r) begin
            state_r <= S_JLOAD;
          end
        end
        S_JLOAD: state_r <= S_SQ;
        S_SQ:    state_r <= S_SQW;
        S_SQW:   state_r <= S_SQA;
        S_SQA: begin
          state_r <= (dim_r == last_dim) ? S_SQRT : S_SQ;
        end
        S_SQRT: begin
          if (step_r == 6'd32) begin
            state_r <= S_GR;
          end
        end
        S_GR:     state_r <= S_GRW;
        S_GRW:    state_r <= S_HSTART;
        S_HSTART: state_r <= S_HDIV;
        S_HDIV: begin
          if (div_rsp.done) begin
            state_r <= side_r ? S_JSEL : S_SQ;
          end
        end
        S_XPREP: begin
          state_r <= (x_hi || x_lo) ? S_FIN : S_XDIV;
        end
        S_XDIV: begin
          if (div_rsp.done) begin
            state_r <= S_NSTART;
          end
        end
        S_NSTART: state_r <= S_NDIV;
        S_NDIV: begin
          if (div_rsp.done) begin
            state_r <= S_TMUL;
          end
        end
        S_TMUL: state_r <= S_TMW;
        S_TMW:  state_r <= S_TDST;
        S_TDST: state_r <= S_TDW;
        S_TDW: begin
          if (div_rsp.done) begin
            state_r <= (k_r == TAYLOR_TERMS) ? S_SHIFT : S_TMUL;
          end
        end
        S_SHIFT: state_r <= S_FIN;
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        new_pos_r   <= {in_data.coord_z, in_data.coord_y, in_data.coord_x};
        p_r         <= in_data.particle[AW-1:0];
        res_ratio_r <= ONE_Q16;
        res_sat_r   <= 1'b0;
      end
      S_SAVE: begin
        jj_r    <= '0;
        ssym_r  <= '0;
        sasym_r <= '0;
      end
      S_JSEL: begin
        if (jj_r != (AW+1)'(PARTICLES) && jj_r[AW-1:0] == p_r) begin
          jj_r <= jj_r + (AW+1)'(1);
        end
      end
      S_JLOAD: begin
        other_r  <= ram_rdata;
        side_r   <= 1'b0;
        dim_r    <= '0;
        sq_acc_r <= '0;
      end
      S_SQ: begin
        mul_a_r <= cabs;
        mul_b_r <= cabs;
      end
      S_SQA: begin
        sq_acc_r <= sq_acc_r + {2'b00, mul_p_r[63:0]};
        dim_r    <= dim_r + 2'd1;
        root_r   <= '0;
        srem_r   <= '0;
        step_r   <= '0;
      end
      S_SQRT: begin
        sq_acc_r <= {sq_acc_r[63:0], 2'b00};
        srem_r   <= sfits ? srem_diff[34:0] : srem_sh[34:0];
        root_r   <= {root_r[31:0], sfits};
        step_r   <= step_r + 6'd1;
      end
      S_GR: begin
        mul_a_r <= 33'(gamma_r);
        mul_b_r <= root_r;
      end
      S_HDIV: begin
        if (div_rsp.done) begin
          if (!side_r) begin
            hnew_r   <= div_rsp.quot[32:0];
            side_r   <= 1'b1;
            dim_r    <= '0;
            sq_acc_r <= '0;
          end else begin
            if (same_half) begin
              ssym_r <= ssym_r + 42'(dh);
            end else begin
              sasym_r <= sasym_r + 42'(dh);
            end
            jj_r <= jj_r + (AW+1)'(1);
          end
        end
      end
      S_XPREP: begin
        if (x_hi) begin
          res_ratio_r <= RATIO_MAX;
          res_sat_r   <= 1'b1;
        end else if (x_lo) begin
          res_ratio_r <= '0;
        end
      end
      S_XDIV: begin
        if (div_rsp.done) begin
          u_r <= uval[37:0];
        end
      end
      S_NDIV: begin
        if (div_rsp.done) begin
          n_r    <= $signed(div_rsp.quot[5:0] - 6'(LN2_BIAS));
          f_r    <= div_rsp.rem[31:0];
          term_r <= 33'h1_0000_0000;
          sum_r  <= 36'h1_0000_0000;
          k_r    <= 4'd1;
        end
      end
      S_TMUL: begin
        mul_a_r <= term_r;
        mul_b_r <= {1'b0, f_r};
      end
      S_TDW: begin
        if (div_rsp.done) begin
          term_r <= div_rsp.quot[32:0];
          sum_r  <= sum_r + 36'(div_rsp.quot[32:0]);
          k_r    <= k_r + 4'd1;
        end
      end
      S_SHIFT: begin
        res_ratio_r <= (|scaled[36:32]) ? RATIO_MAX : scaled[31:0];
        res_sat_r   <= |scaled[36:32];
      end
      default: begin
        res_sat_r <= res_sat_r;
      end
    endcase
  end

endmodule

[test/pade_jastrow_move_ratio_tb.sv]
// Testbench for pade_jastrow_move_ratio: random and directed load, move and
// reject transactions checked against a bit-exact Pade-Jastrow ratio predictor.
// Depends on pjmr_pkg for the payload types, request codes and constants.
`timescale 1ns / 100ps

module pade_jastrow_move_ratio_tb;
  import pjmr_pkg::*;

  localparam int NPART = 8;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam logic [1:0] REQ_NOP = 2'd3;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } coord_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pjmr_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pjmr_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pade_jastrow_move_ratio #(.PARTICLES(NPART)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Predictor state and configuration.
  logic [19:0] pade_gamma = GAMMA_RESET;
  logic [1:0] dim_sel = DIMS_RESET;
  coord_t pos_mem [NPART];
  coord_t saved_pos = '0;
  logic [5:0] saved_idx = '0;
  logic move_open = 1'b0;

  pjmr_in_t pending_items [$];
  pjmr_out_t ratio_q [$];
  int errors = 0;
  logic in_took = 1'b0;
  int in_gap = 0;
  int out_hold = 0;
  logic calm = 1'b0;
  logic stall_req = 1'b0;
  logic stall_done = 1'b0;
  int idle_cycles = 0;

  function automatic longint floor_div(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q--;
    return q;
  endfunction

  // Bitwise integer square root of a 66-bit value.
  function automatic logic [33:0] isqrt66(logic [65:0] s);
    logic [69:0] rem, trial;
    logic [33:0] root;
    rem = '0;
    root = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | 70'((s >> (2 * i)) & 66'd3);
      trial = (70'(root) << 2) | 70'd1;
      root = root << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 34'd1;
      end
    end
    return root;
  endfunction

  function automatic logic [31:0] axis(coord_t c, int d);
    return (d == 0) ? c.x : (d == 1) ? c.y : c.z;
  endfunction

  // Pade term h = r / (1 + gamma*r) in Q16.16 for the distance between a and b.
  function automatic longint pade_term(coord_t a, coord_t b);
    logic signed [32:0] df;
    logic [32:0] m;
    logic [67:0] s;
    logic [33:0] r;
    logic [127:0] num, den;
    logic [31:0] ca, cb;
    int nd;
    nd = (dim_sel == 2'd2) ? 2 : 3;
    s = '0;
    for (int d = 0; d < nd; d++) begin
      ca = axis(a, d);
      cb = axis(b, d);
      df = $signed({ca[31], ca}) - $signed({cb[31], cb});
      m = df[32] ? 33'(-df) : 33'(df);
      s = s + (68'(m) * 68'(m));
    end
    r = isqrt66(s[65:0]);
    den = 128'h1_0000_0000 + 128'(pade_gamma) * 128'(r);
    num = 128'(r) << 32;
    return longint'(num / den);
  endfunction

  // Fixed-point exponential with saturation flag.
  function automatic pjmr_out_t exp_ratio(longint x);
    pjmr_out_t o;
    longint x32, n, f, ln2;
    logic [127:0] term, acc, res;
    int sh;
    o = '0;
    if (x > EXP_LIMIT) begin
      o.ratio = RATIO_MAX;
      o.saturated = 1'b1;
      return o;
    end
    if (x < -EXP_LIMIT) return o;
    ln2 = longint'({32'd0, LN2_Q32});
    x32 = x * 65536;
    n = floor_div(x32, ln2);
    f = x32 - n * ln2;
    term = 128'h1_0000_0000;
    acc = term;
    for (int k = 1; k <= 13; k++) begin
      term = ((term * 128'(f)) >> 32) / 128'(k);
      acc = acc + term;
    end
    if (n >= 16) begin
      res = acc << (n - 16);
    end else begin
      sh = 16 - int'(n);
      res = (acc + (128'd1 << (sh - 1))) >> sh;
    end
    if (res > 128'hFFFF_FFFF) begin
      o.ratio = RATIO_MAX;
      o.saturated = 1'b1;
    end else begin
      o.ratio = res[31:0];
    end
    return o;
  endfunction

  // Applies one accepted transaction to the predictor state and returns its result.
  function automatic pjmr_out_t predict_ratio(pjmr_in_t it);
    pjmr_out_t o;
    coord_t np;
    longint ssym, sasym, dh, x;
    int p;
    o.ratio = ONE_Q16;
    o.saturated = 1'b0;
    np = {it.coord_x, it.coord_y, it.coord_z};
    p = it.particle;
    if (it.req_type == REQ_LOAD && p < NPART) begin
      pos_mem[p] = np;
      move_open = 1'b0;
    end else if (it.req_type == REQ_MOVE && p < NPART) begin
      saved_pos = pos_mem[p];
      saved_idx = it.particle;
      move_open = 1'b1;
      pos_mem[p] = np;
      ssym = 0;
      sasym = 0;
      for (int j = 0; j < NPART; j++) begin
        if (j != p) begin
          dh = pade_term(np, pos_mem[j]) - pade_term(saved_pos, pos_mem[j]);
          if ((j < NPART / 2) == (p < NPART / 2)) ssym += dh;
          else sasym += dh;
        end
      end
      if (dim_sel == 2'd2) x = floor_div(2 * ssym + 6 * sasym, 3);
      else x = floor_div(ssym + 2 * sasym, 2);
      o = exp_ratio(x);
    end else if (it.req_type == REQ_REJECT && move_open) begin
      if (saved_idx < NPART) pos_mem[saved_idx] = saved_pos;
      move_open = 1'b0;
    end
    return o;
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 32'($signed($urandom_range(0, 262143)) - 131072);
    if (r < 8) return 32'($signed($urandom_range(0, 33554431)) - 16777216);
    if (r == 8) return $urandom;
    case ($urandom_range(0, 2))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return 32'd0;
    endcase
  endfunction

  function automatic pjmr_in_t make_item(logic [1:0] req, logic [5:0] p,
                                         logic [31:0] x, logic [31:0] y, logic [31:0] z);
    pjmr_in_t it;
    it.req_type = req;
    it.particle = p;
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    return it;
  endfunction

  function automatic pjmr_in_t rand_item();
    int r;
    logic [5:0] p;
    r = $urandom_range(0, 99);
    p = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, NPART - 1));
    if (r < 30) return make_item(REQ_LOAD, p, rand_coord(), rand_coord(), rand_coord());
    if (r < 70) return make_item(REQ_MOVE, p, rand_coord(), rand_coord(), rand_coord());
    if (r < 92) return make_item(REQ_REJECT, p, $urandom, $urandom, $urandom);
    return make_item(REQ_NOP, p, $urandom, $urandom, $urandom);
  endfunction

  // Input driver: holds a transaction until it is taken, then inserts a gap.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_took)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side ready: random back-pressure plus one long hold-off on request.
  always @(negedge clk) begin
    if (stall_req && !stall_done) begin
      stall_done <= 1'b1;
      out_hold <= 4000;
      out_ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) < 3) begin
      out_hold <= pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predicts on each input transaction, checks each result transaction.
  always @(posedge clk) begin
    pjmr_out_t want;
    in_took = in_valid && in_ready && rst_n;
    if (in_took) ratio_q.push_back(predict_ratio(in_data));
    if (rst_n && out_valid && out_ready) begin
      if (ratio_q.size() == 0) begin
        $display("%0t: unexpected result ratio=%h saturated=%b",
                 $time, out_data.ratio, out_data.saturated);
        errors++;
      end else begin
        want = ratio_q.pop_front();
        if (want.ratio !== out_data.ratio) begin
          $display("%0t: ratio expected %h actual %h", $time, want.ratio, out_data.ratio);
          errors++;
        end
        if (want.saturated !== out_data.saturated) begin
          $display("%0t: saturated expected %b actual %b",
                   $time, want.saturated, out_data.saturated);
          errors++;
        end
      end
    end
    if (in_took || (out_valid && out_ready) || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Waits at rising edges, where the driver's outputs have settled, until
  // every queued transaction has been sent and every result has come back.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || ratio_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_GAMMA) pade_gamma = val[19:0];
    else if (idx == CFG_DIMS) dim_sel = val[1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < NPART; i++)
      pending_items.push_back(make_item(REQ_LOAD, 6'(i), rand_coord(), rand_coord(), rand_coord()));
    for (int i = 0; i < count; i++) pending_items.push_back(rand_item());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under reset configuration: every position is loaded first.
    for (int i = 0; i < NPART; i++)
      pending_items.push_back(make_item(REQ_LOAD, 6'(i), 32'(i * 40000),
                                        32'(-i * 30000), 32'(i * 5000)));
    pending_items.push_back(make_item(REQ_MOVE, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_items.push_back(make_item(REQ_REJECT, 6'd0, 0, 0, 0));
    pending_items.push_back(make_item(REQ_REJECT, 6'd0, 0, 0, 0));
    pending_items.push_back(make_item(REQ_MOVE, 6'd7, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    pending_items.push_back(make_item(REQ_LOAD, 6'd3, 32'd0, 32'd0, 32'd0));
    pending_items.push_back(make_item(REQ_REJECT, 6'd7, 0, 0, 0));
    pending_items.push_back(make_item(REQ_MOVE, 6'd2, 32'd65536, 32'd0, 32'd0));
    pending_items.push_back(make_item(REQ_MOVE, 6'd5, 32'd0, 32'd65536, 32'd0));
    pending_items.push_back(make_item(REQ_REJECT, 6'd2, 0, 0, 0));
    pending_items.push_back(make_item(REQ_NOP, 6'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(REQ_LOAD, 6'd63, 32'h1234_5678, 0, 0));
    pending_items.push_back(make_item(REQ_MOVE, 6'd63, 32'h1234_5678, 0, 0));
    pending_items.push_back(make_item(REQ_MOVE, 6'd1, 32'd40000, 32'(-30000), 32'd5000));
    pending_items.push_back(make_item(REQ_MOVE, 6'd4, 0, 0, 0));
    wait_drained();

    // Saturation and underflow extremes with gamma zero, 2D.
    write_reg(CFG_GAMMA, 32'd0 | (32'($urandom) & 32'hFFF0_0000));
    write_reg(CFG_DIMS, 32'd2);
    random_phase(280);
    stall_req = 1'b1;
    wait_drained();

    // Largest gamma, 3D.
    write_reg(CFG_GAMMA, 32'h000F_FFFF);
    write_reg(CFG_DIMS, 32'd3);
    calm = 1'b1;
    random_phase(100);
    wait_drained();
    calm = 1'b0;
    random_phase(200);
    wait_drained();

    // Random gamma, 2D.
    write_reg(CFG_GAMMA, $urandom);
    write_reg(CFG_DIMS, 32'd2 | (32'($urandom) & 32'hFFFF_FFFC));
    random_phase(300);
    wait_drained();

    // Small gamma, dims code that selects 3D by default.
    write_reg(CFG_GAMMA, 32'h0000_1000);
    write_reg(CFG_DIMS, 32'd0);
    random_phase(280);
    wait_drained();

    // Back to unit gamma, dims code one.
    write_reg(CFG_GAMMA, 32'd65536);
    write_reg(CFG_DIMS, 32'd1);
    random_phase(280);
    wait_drained();

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
